>>> rtl/mandelbrot_escape_time_assert.svh
// ---------------------------------------------------------------------------
// Mandelbrot escape-time assertion macros
// Concurrent assertion wrappers shared by the datapath and the top level. They
// expand to nothing when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_TIME_ASSERT_SVH
`define MANDELBROT_ESCAPE_TIME_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define MBE_ASSERT_IMPL(name, clk_sig, rst_n_sig, ante, cons) \
	name: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (ante) |-> (cons)) \
		else $error("mandelbrot_escape_time assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define MBE_ASSERT_NEXT(name, clk_sig, rst_n_sig, ante, cons) \
	name: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (ante) |=> (cons)) \
		else $error("mandelbrot_escape_time assertion failed");
`else
`define MBE_ASSERT_IMPL(name, clk_sig, rst_n_sig, ante, cons)
`define MBE_ASSERT_NEXT(name, clk_sig, rst_n_sig, ante, cons)
`endif
`endif

>>> rtl/mbe_pkg.sv
// ---------------------------------------------------------------------------
// Mandelbrot escape-time package
// Field widths, register indexes and the command and status types that join
// the controller to the datapath.
// ---------------------------------------------------------------------------
package mbe_pkg;

	localparam int FRAC_BITS_DEF = 24;
	localparam int MAX_RES_DEF   = 4096;

	localparam int PIX_W     = 12;
	localparam int IN_W      = 2 * PIX_W;
	localparam int WIN_W     = 32;
	localparam int RES_W     = 13;
	localparam int ITER_W    = 8;
	localparam int CFG_IDX_W = 3;

	// Magnitude of pixel times span, and the divider step counter.
	localparam int PROD_W = PIX_W + WIN_W - 1;
	localparam int DCNT_W = $clog2(PROD_W + 1);

	// Stored z components are limited to a magnitude of 2^32 - 1.
	localparam int ZMAG_W = 32;
	localparam int Z_W    = ZMAG_W + 1;

	localparam logic [CFG_IDX_W-1:0] REG_WIN_X_MIN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIN_X_SPAN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WIN_Y_MIN  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WIN_Y_SPAN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RES_X      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RES_Y      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER   = 3'd6;

	typedef struct packed {
		logic start;
		logic div_step;
		logic map_end;
		logic mul;
		logic add;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic div_done;
		logic lim_zero;
		logic iter_last;
	} dp_status_t;

endpackage

>>> rtl/mbe_ctrl.sv
// ---------------------------------------------------------------------------
// Mandelbrot escape-time controller
// Sequences one pixel through mapping division, iteration and result
// hand-over, and owns the handshakes of both stream sides.
// ---------------------------------------------------------------------------
module mbe_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_valid,
	output logic                 s_ready,
	output logic                 m_valid,
	input  logic                 m_ready,
	output mbe_pkg::dp_cmd_t     cmd,
	input  mbe_pkg::dp_status_t  status
);
	import mbe_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_MAP  = 5'b00010,
		ST_MUL  = 5'b00100,
		ST_ADD  = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   m_valid_q;
	logic   out_free;

	assign out_free = !m_valid_q || m_ready;
	assign s_ready  = (state_q == ST_IDLE);
	assign m_valid  = m_valid_q;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				if (s_valid) begin
					cmd.start = 1'b1;
					state_nxt = ST_MAP;
				end
			end
			ST_MAP: begin
				if (!status.div_done) begin
					cmd.div_step = 1'b1;
				end else begin
					cmd.map_end = 1'b1;
					state_nxt   = status.lim_zero ? ST_DONE : ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul   = 1'b1;
				state_nxt = ST_ADD;
			end
			ST_ADD: begin
				cmd.add   = 1'b1;
				state_nxt = status.iter_last ? ST_DONE : ST_MUL;
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_ready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/mbe_datapath.sv
// ---------------------------------------------------------------------------
// Mandelbrot escape-time datapath
// Two restoring dividers map the pixel into the window, then one shared
// complex square-and-add unit iterates z, products first and sums after.
// ---------------------------------------------------------------------------
`include "mandelbrot_escape_time_assert.svh"

module mbe_datapath #(
	parameter int FRAC_BITS = mbe_pkg::FRAC_BITS_DEF,
	parameter int MAX_RES   = mbe_pkg::MAX_RES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  mbe_pkg::dp_cmd_t                   cmd,
	output mbe_pkg::dp_status_t                status,
	input  logic [mbe_pkg::IN_W-1:0]           in_data,
	input  logic signed [mbe_pkg::WIN_W-1:0]   win_x_min,
	input  logic signed [mbe_pkg::WIN_W-1:0]   win_x_span,
	input  logic signed [mbe_pkg::WIN_W-1:0]   win_y_min,
	input  logic signed [mbe_pkg::WIN_W-1:0]   win_y_span,
	input  logic [mbe_pkg::RES_W-1:0]          res_x,
	input  logic [mbe_pkg::RES_W-1:0]          res_y,
	input  logic [mbe_pkg::ITER_W-1:0]         max_iter,
	output logic [mbe_pkg::ITER_W-1:0]         iterations,
	output logic                               in_set
);
	import mbe_pkg::*;

	localparam int PW     = 2 * ZMAG_W;
	localparam int TW     = PW - FRAC_BITS;
	localparam int SW     = TW + 3;
	localparam int MAG_W  = TW + 1;
	localparam int CW     = PROD_W + 2;
	localparam int RES_TOP = (1 << RES_W) - 1;
	localparam int RES_CAP = (MAX_RES < RES_TOP) ? MAX_RES : RES_TOP;

	localparam logic [MAG_W-1:0] FOUR = MAG_W'(4) << FRAC_BITS;
	localparam logic signed [WIN_W-1:0] W_MAX = {1'b0, {(WIN_W-1){1'b1}}};
	localparam logic signed [WIN_W-1:0] W_MIN = {1'b1, {(WIN_W-1){1'b0}}};
	localparam logic signed [SW-1:0] Z_SAT_HI = $signed({{(SW-ZMAG_W){1'b0}}, {ZMAG_W{1'b1}}});
	localparam logic signed [SW-1:0] Z_SAT_LO = -Z_SAT_HI;
	localparam logic signed [Z_W-1:0] Z_NEG_LIMIT = {1'b1, {ZMAG_W{1'b0}}};

	// Mapping lanes: index 0 is the real axis, index 1 the imaginary axis.
	logic [PIX_W-1:0]        pix_a [2];
	logic signed [WIN_W-1:0] span_a [2];
	logic signed [WIN_W-1:0] min_a [2];
	logic [RES_W-1:0]        res_a [2];
	logic [WIN_W-1:0]        span_mag [2];
	logic [PIX_W+WIN_W-1:0]  prod_full [2];
	logic [RES_W-1:0]        div_clamp [2];
	logic [RES_W:0]          trial [2];
	logic [RES_W:0]          trial_sub [2];
	logic signed [CW-1:0]    q_signed [2];
	logic signed [CW-1:0]    c_sum [2];
	logic signed [WIN_W-1:0] c_sat [2];

	logic [PROD_W-1:0]       quo_q [2];
	logic [RES_W-1:0]        rem_q [2];
	logic [RES_W-1:0]        dvs_q [2];
	logic                    neg_q [2];
	logic signed [WIN_W-1:0] c_q [2];
	logic [DCNT_W-1:0]       dcnt_q;
	logic [ITER_W-1:0]       lim_q;

	// Iteration state.
	logic signed [Z_W-1:0]   zx_q;
	logic signed [Z_W-1:0]   zy_q;
	logic [ITER_W-1:0]       cnt_q;
	logic [PW-1:0]           pxx_q;
	logic [PW-1:0]           pyy_q;
	logic [PW-1:0]           pxy_q;
	logic                    xy_neg_q;
	logic [ITER_W-1:0]       out_iter_q;
	logic                    out_in_set_q;

	logic [ZMAG_W-1:0]       ax;
	logic [ZMAG_W-1:0]       ay;
	logic [Z_W-1:0]          zx_neg;
	logic [Z_W-1:0]          zy_neg;
	logic signed [SW-1:0]    xx_w;
	logic signed [SW-1:0]    yy_w;
	logic signed [SW-1:0]    xy_mag;
	logic signed [SW-1:0]    xy_w;
	logic signed [SW-1:0]    nx_w;
	logic signed [SW-1:0]    ny_w;
	logic signed [Z_W-1:0]   zx_nxt;
	logic signed [Z_W-1:0]   zy_nxt;
	logic [MAG_W-1:0]        mag_w;
	logic                    esc;
	logic [ITER_W-1:0]       cnt_inc;

	always_comb begin
		pix_a[0]  = in_data[PIX_W-1:0];
		pix_a[1]  = in_data[IN_W-1:PIX_W];
		span_a[0] = win_x_span;
		span_a[1] = win_y_span;
		min_a[0]  = win_x_min;
		min_a[1]  = win_y_min;
		res_a[0]  = res_x;
		res_a[1]  = res_y;
		for (int l = 0; l < 2; l++) begin
			span_mag[l]  = span_a[l][WIN_W-1] ? WIN_W'(-span_a[l]) : WIN_W'(span_a[l]);
			prod_full[l] = pix_a[l] * span_mag[l];
			if (res_a[l] == '0) begin
				div_clamp[l] = RES_W'(1);
			end else if (32'(res_a[l]) > RES_CAP) begin
				div_clamp[l] = RES_W'(RES_CAP);
			end else begin
				div_clamp[l] = res_a[l];
			end
			trial[l]     = {rem_q[l], quo_q[l][PROD_W-1]};
			trial_sub[l] = trial[l] - {1'b0, dvs_q[l]};
			q_signed[l]  = neg_q[l] ? -$signed(CW'(quo_q[l])) : $signed(CW'(quo_q[l]));
			c_sum[l]     = q_signed[l] + CW'(min_a[l]);
			if (c_sum[l] > CW'(W_MAX)) begin
				c_sat[l] = W_MAX;
			end else if (c_sum[l] < CW'(W_MIN)) begin
				c_sat[l] = W_MIN;
			end else begin
				c_sat[l] = c_sum[l][WIN_W-1:0];
			end
		end
	end

	always_comb begin
		zx_neg = -zx_q;
		zy_neg = -zy_q;
		ax     = zx_q[Z_W-1] ? zx_neg[ZMAG_W-1:0] : zx_q[ZMAG_W-1:0];
		ay     = zy_q[Z_W-1] ? zy_neg[ZMAG_W-1:0] : zy_q[ZMAG_W-1:0];

		xx_w   = $signed(SW'(pxx_q[PW-1:FRAC_BITS]));
		yy_w   = $signed(SW'(pyy_q[PW-1:FRAC_BITS]));
		xy_mag = $signed(SW'(pxy_q[PW-1:FRAC_BITS]));
		xy_w   = xy_neg_q ? -xy_mag : xy_mag;
		nx_w   = xx_w - yy_w + SW'(c_q[0]);
		ny_w   = (xy_w <<< 1) + SW'(c_q[1]);

		if (nx_w > Z_SAT_HI) begin
			zx_nxt = Z_W'(Z_SAT_HI);
		end else if (nx_w < Z_SAT_LO) begin
			zx_nxt = Z_W'(Z_SAT_LO);
		end else begin
			zx_nxt = nx_w[Z_W-1:0];
		end
		if (ny_w > Z_SAT_HI) begin
			zy_nxt = Z_W'(Z_SAT_HI);
		end else if (ny_w < Z_SAT_LO) begin
			zy_nxt = Z_W'(Z_SAT_LO);
		end else begin
			zy_nxt = ny_w[Z_W-1:0];
		end

		// The escape test looks at the magnitude of the z that went in.
		mag_w   = MAG_W'(pxx_q[PW-1:FRAC_BITS]) + MAG_W'(pyy_q[PW-1:FRAC_BITS]);
		esc     = (mag_w >= FOUR);
		cnt_inc = cnt_q + ITER_W'(1);
	end

	assign status.div_done  = (dcnt_q == DCNT_W'(PROD_W));
	assign status.lim_zero  = (lim_q == '0);
	assign status.iter_last = esc || (cnt_inc == lim_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
			zx_q   <= '0;
			zy_q   <= '0;
		end else begin
			if (cmd.start) begin
				dcnt_q <= '0;
			end else if (cmd.div_step) begin
				dcnt_q <= dcnt_q + DCNT_W'(1);
			end
			if (cmd.map_end) begin
				zx_q <= '0;
				zy_q <= '0;
			end else if (cmd.add) begin
				zx_q <= zx_nxt;
				zy_q <= zy_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < 2; l++) begin
			if (cmd.start) begin
				quo_q[l] <= prod_full[l][PROD_W-1:0];
				rem_q[l] <= '0;
				dvs_q[l] <= div_clamp[l];
				neg_q[l] <= span_a[l][WIN_W-1];
			end else if (cmd.div_step) begin
				if (!trial_sub[l][RES_W]) begin
					rem_q[l] <= trial_sub[l][RES_W-1:0];
					quo_q[l] <= {quo_q[l][PROD_W-2:0], 1'b1};
				end else begin
					rem_q[l] <= trial[l][RES_W-1:0];
					quo_q[l] <= {quo_q[l][PROD_W-2:0], 1'b0};
				end
			end
			if (cmd.map_end) begin
				c_q[l] <= c_sat[l];
			end
		end
		if (cmd.start) begin
			lim_q <= max_iter;
		end
		if (cmd.map_end) begin
			cnt_q <= '0;
		end else if (cmd.add) begin
			cnt_q <= cnt_inc;
		end
		if (cmd.mul) begin
			pxx_q    <= ax * ax;
			pyy_q    <= ay * ay;
			pxy_q    <= ax * ay;
			xy_neg_q <= zx_q[Z_W-1] ^ zy_q[Z_W-1];
		end
		if (cmd.out_load) begin
			out_iter_q   <= cnt_q;
			out_in_set_q <= (cnt_q == lim_q);
		end
	end

	assign iterations = out_iter_q;
	assign in_set     = out_in_set_q;

	`MBE_ASSERT_IMPL(a_div_count_bound, clk, arst_n, 1'b1, dcnt_q <= DCNT_W'(PROD_W))
	`MBE_ASSERT_IMPL(a_z_saturated, clk, arst_n, 1'b1, (zx_q != Z_NEG_LIMIT) && (zy_q != Z_NEG_LIMIT))
	`MBE_ASSERT_IMPL(a_iter_below_limit, clk, arst_n, cmd.mul, cnt_q < lim_q)

endmodule

>>> rtl/mandelbrot_escape_time.sv
// ---------------------------------------------------------------------------
// Mandelbrot escape-time unit
// Maps a pixel into a configured complex window and returns how many steps
// of z = z^2 + c it takes to escape, in signed fixed point.
// ---------------------------------------------------------------------------
// One pixel is in work at a time. An item passes through these steps in order:
// the transfer is taken, 43 steps of the restoring divider map both axes in
// parallel, c is formed and registered, then each iteration of the shared
// square-and-add unit forms the products in one state and the sums and the
// escape test in the state after it, and finally the result is handed to the
// output register. The next pixel is taken while a finished result still
// waits in the output register. Configuration writes are always accepted but
// must only be made while no pixel is in work.
`include "mandelbrot_escape_time_assert.svh"

module mandelbrot_escape_time #(
	parameter int FRAC_BITS = mbe_pkg::FRAC_BITS_DEF,
	parameter int MAX_RES   = mbe_pkg::MAX_RES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [mbe_pkg::IN_W-1:0]        s_axis_tdata,   // pixel_x, pixel_y
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [mbe_pkg::ITER_W-1:0]      m_axis_tdata,   // iterations
	output logic                            m_axis_tuser,   // in_set
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [mbe_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mbe_pkg::WIN_W-1:0]       cfg_data
);
	import mbe_pkg::*;

	localparam logic signed [WIN_W-1:0] RST_X_MIN  = -(32'sd2 <<< FRAC_BITS);
	localparam logic signed [WIN_W-1:0] RST_X_SPAN = 32'sd3 <<< FRAC_BITS;
	localparam logic signed [WIN_W-1:0] RST_Y_MIN  = -(32'sd1 <<< FRAC_BITS);
	localparam logic signed [WIN_W-1:0] RST_Y_SPAN = 32'sd2 <<< FRAC_BITS;

	logic signed [WIN_W-1:0] win_x_min_q;
	logic signed [WIN_W-1:0] win_x_span_q;
	logic signed [WIN_W-1:0] win_y_min_q;
	logic signed [WIN_W-1:0] win_y_span_q;
	logic [RES_W-1:0]        res_x_q;
	logic [RES_W-1:0]        res_y_q;
	logic [ITER_W-1:0]       max_iter_q;

	dp_cmd_t    cmd;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_x_min_q  <= RST_X_MIN;
			win_x_span_q <= RST_X_SPAN;
			win_y_min_q  <= RST_Y_MIN;
			win_y_span_q <= RST_Y_SPAN;
			res_x_q      <= RES_W'(640);
			res_y_q      <= RES_W'(480);
			max_iter_q   <= ITER_W'(255);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_WIN_X_MIN:  win_x_min_q  <= cfg_data;
				REG_WIN_X_SPAN: win_x_span_q <= cfg_data;
				REG_WIN_Y_MIN:  win_y_min_q  <= cfg_data;
				REG_WIN_Y_SPAN: win_y_span_q <= cfg_data;
				REG_RES_X:      res_x_q      <= cfg_data[RES_W-1:0];
				REG_RES_Y:      res_y_q      <= cfg_data[RES_W-1:0];
				REG_MAX_ITER:   max_iter_q   <= cfg_data[ITER_W-1:0];
				default: begin
				end
			endcase
		end
	end

	mbe_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.s_ready (s_axis_tready),
		.m_valid (m_axis_tvalid),
		.m_ready (m_axis_tready),
		.cmd     (cmd),
		.status  (status)
	);

	mbe_datapath #(
		.FRAC_BITS (FRAC_BITS),
		.MAX_RES   (MAX_RES)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.in_data    (s_axis_tdata),
		.win_x_min  (win_x_min_q),
		.win_x_span (win_x_span_q),
		.win_y_min  (win_y_min_q),
		.win_y_span (win_y_span_q),
		.res_x      (res_x_q),
		.res_y      (res_y_q),
		.max_iter   (max_iter_q),
		.iterations (m_axis_tdata),
		.in_set     (m_axis_tuser)
	);

	`MBE_ASSERT_NEXT(a_one_pixel_in_work, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
	`MBE_ASSERT_NEXT(a_no_instant_result, clk, arst_n, s_axis_tvalid && s_axis_tready, !$rose(m_axis_tvalid))
	`MBE_ASSERT_IMPL(a_ready_after_result, clk, arst_n, $rose(m_axis_tvalid), s_axis_tready)

endmodule
